@@ src/mbs_pkg.sv @@
// ----------------------------------------------------------------------------
// mbs_pkg: shared types and constants of the minimum 3x3 box sum block
// widths of the item fields, register map and stage control records
// ----------------------------------------------------------------------------
package mbs_pkg;

  localparam int unsigned SAMPLE_W = 17;
  localparam int unsigned CSUM_W   = 19;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned GW_W     = 11;
  localparam int unsigned GH_W     = 16;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned LINE_W   = 2 * SAMPLE_W;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [GW_W-1:0]    WIDTH_RST = GW_W'(3);
  localparam logic [GH_W-1:0]    HEIGHT_MIN = GH_W'(3);
  localparam logic [GH_W-1:0]    HEIGHT_RST = GH_W'(3);
  localparam logic [GH_W-1:0]    WIN_ROW   = GH_W'(2);

  localparam logic [PADDR_W-1:0] REG_GRID_WIDTH  = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] REG_GRID_HEIGHT = PADDR_W'(4);

  typedef struct packed {
    logic [GW_W-1:0] grid_width;
    logic [GH_W-1:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic win_en;
    logic last;
  } stage_t;

endpackage

@@ src/mbs_stream_if.sv @@
// ----------------------------------------------------------------------------
// mbs stream interfaces: valid/ready channels for samples and results
// an item moves on a rising edge with valid and ready both high
// ----------------------------------------------------------------------------
interface mbs_smp_if;
  logic                          valid;
  logic                          ready;
  logic [mbs_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mbs_res_if;
  logic                       valid;
  logic                       ready;
  logic [mbs_pkg::SUM_W-1:0]  min_window_sum;

  modport source (output valid, output min_window_sum, input ready);
  modport sink   (input valid, input min_window_sum, output ready);
endinterface

@@ src/mbs_ram.sv @@
// ----------------------------------------------------------------------------
// mbs_ram: generic simple dual-port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module mbs_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mbs_cfg.sv @@
// ----------------------------------------------------------------------------
// mbs_cfg: apb register file
// holds grid width and grid height, always ready, reads return the value
// ----------------------------------------------------------------------------
module mbs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbs_pkg::PADDR_W-1:0]    paddr,
  input  logic [mbs_pkg::PDATA_W-1:0]    pwdata,
  output logic [mbs_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  output mbs_pkg::cfg_t                  cfg_o
);
  import mbs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr)
        REG_GRID_WIDTH:  cfg_d.grid_width  = pwdata[GW_W-1:0];
        REG_GRID_HEIGHT: cfg_d.grid_height = pwdata[GH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= WIDTH_RST;
      cfg_q.grid_height <= HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr)
      REG_GRID_WIDTH:  prdata = PDATA_W'(cfg_q.grid_width);
      REG_GRID_HEIGHT: prdata = PDATA_W'(cfg_q.grid_height);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/mbs_pos.sv @@
// ----------------------------------------------------------------------------
// mbs_pos: raster position tracking and line store read issue
// counts column and row, flags window and grid end, registers the item
// ----------------------------------------------------------------------------
module mbs_pos #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned CW        = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbs_pkg::cfg_t                 cfg_i,
  mbs_smp_if.sink                       smp_i,
  input  logic                          out_full_i,
  output logic                          rd_en_o,
  output logic [CW-1:0]                 rd_addr_o,
  output logic                          s1_valid_o,
  output mbs_pkg::stage_t               s1_ctl_o,
  output logic [mbs_pkg::SAMPLE_W-1:0]  s1_sample_o,
  output logic [CW-1:0]                 s1_addr_o
);
  import mbs_pkg::*;

  localparam int unsigned WW = ((CW > GW_W) ? CW : GW_W) + 1;
  localparam logic [WW-1:0] W_MIN = WW'(3);
  localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
  localparam logic [CW-1:0] WIN_COL = CW'(2);

  logic [CW-1:0]       col_q, col_d;
  logic [GH_W-1:0]     row_q, row_d;
  logic [WW-1:0]       w_ext, w_eff;
  logic [GH_W-1:0]     h_eff;
  logic                col_end, row_end, is_last, accept;
  logic                s1_valid_q;
  stage_t              s1_ctl_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [CW-1:0]       s1_addr_q;

  assign w_ext = WW'(cfg_i.grid_width);
  assign w_eff = (w_ext < W_MIN) ? W_MIN : ((w_ext > W_MAX) ? W_MAX : w_ext);
  assign h_eff = (cfg_i.grid_height < HEIGHT_MIN) ? HEIGHT_MIN : cfg_i.grid_height;

  assign col_end = WW'(col_q) >= (w_eff - WW'(1));
  assign row_end = row_q >= (h_eff - GH_W'(1));
  assign is_last = col_end & row_end;

  // a grid end item may only enter when the result slot is free
  assign smp_i.ready = ~(is_last & out_full_i);
  assign accept      = smp_i.valid & smp_i.ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + GH_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q.win_en <= (col_q >= WIN_COL) & (row_q >= WIN_ROW);
      s1_ctl_q.last   <= is_last;
      s1_sample_q     <= smp_i.sample;
      s1_addr_q       <= col_q;
    end
  end

  assign rd_en_o     = accept;
  assign rd_addr_o   = col_q;
  assign s1_valid_o  = s1_valid_q;
  assign s1_ctl_o    = s1_ctl_q;
  assign s1_sample_o = s1_sample_q;
  assign s1_addr_o   = s1_addr_q;

endmodule

@@ src/mbs_win.sv @@
// ----------------------------------------------------------------------------
// mbs_win: column and window sum, running minimum, result register
// writes the shifted column back to the line store
// ----------------------------------------------------------------------------
module mbs_win #(
  parameter int unsigned CW = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  input  mbs_pkg::stage_t               s1_ctl_i,
  input  logic [mbs_pkg::SAMPLE_W-1:0]  s1_sample_i,
  input  logic [CW-1:0]                 s1_addr_i,
  input  logic [mbs_pkg::LINE_W-1:0]    rd_data_i,
  output logic                          wr_en_o,
  output logic [CW-1:0]                 wr_addr_o,
  output logic [mbs_pkg::LINE_W-1:0]    wr_data_o,
  output logic                          out_full_o,
  mbs_res_if.source                     res_o
);
  import mbs_pkg::*;

  logic [SAMPLE_W-1:0] prev, prev2;
  logic [CSUM_W-1:0]   col_sum;
  logic [CSUM_W-1:0]   cs0_q, cs1_q;
  logic [SUM_W:0]      win_raw;
  logic [SUM_W-1:0]    win_sat, cand;
  logic [SUM_W-1:0]    min_q;
  logic                out_valid_q;
  logic [SUM_W-1:0]    out_data_q;

  // entry layout: upper half is the previous row, lower half the one before
  assign prev  = rd_data_i[LINE_W-1:SAMPLE_W];
  assign prev2 = rd_data_i[SAMPLE_W-1:0];

  assign col_sum = CSUM_W'(s1_sample_i) + CSUM_W'(prev) + CSUM_W'(prev2);
  assign win_raw = (SUM_W+1)'(col_sum) + (SUM_W+1)'(cs0_q) + (SUM_W+1)'(cs1_q);
  assign win_sat = win_raw[SUM_W] ? SUM_MAX : win_raw[SUM_W-1:0];
  assign cand    = (s1_ctl_i.win_en && (win_sat < min_q)) ? win_sat : min_q;

  assign wr_en_o   = s1_valid_i;
  assign wr_addr_o = s1_addr_i;
  assign wr_data_o = {s1_sample_i, prev};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs0_q       <= '0;
      cs1_q       <= '0;
      min_q       <= SUM_MAX;
      out_valid_q <= 1'b0;
    end else begin
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_valid_i) begin
        if (s1_ctl_i.last) begin
          cs0_q       <= '0;
          cs1_q       <= '0;
          min_q       <= SUM_MAX;
          out_valid_q <= 1'b1;
        end else begin
          cs0_q <= col_sum;
          cs1_q <= cs0_q;
          min_q <= cand;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ctl_i.last) begin
      out_data_q <= cand;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.min_window_sum = out_data_q;
  assign out_full_o           = out_valid_q;

endmodule

@@ src/min_box3x3_sum.sv @@
// ----------------------------------------------------------------------------
// min_box3x3_sum: least 3x3 window sum over a raster grid
// Samples enter on smp_i in row-major order, one item per sample. Grid width
// and height are set over the apb port (width at 0x0, height at 0x4); the
// user must write them only while the block is idle (not enforced). One
// result leaves on res_o after the last sample of each grid: the smallest 3x3
// window sum, saturated at 20 bits; the block then clears for the next grid.
// Throughput is one sample per cycle, but a grid's last sample waits while
// a result is held. Each sample reads its column of the line store in the
// cycle it is accepted and writes it back in the next cycle; repeats of one
// column are at least three items apart, so no forwarding.
// A result waits in an output register while res_o is stalled; samples keep
// flowing, only the last sample of the next grid waits for that register.
// Reset clears counters, column sums and the minimum; the line store is not
// cleared, as each grid writes a column before reading it back.
// ----------------------------------------------------------------------------
module min_box3x3_sum #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbs_pkg::PADDR_W-1:0]    paddr,
  input  logic [mbs_pkg::PDATA_W-1:0]    pwdata,
  output logic [mbs_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  mbs_smp_if.sink                        smp_i,
  mbs_res_if.source                      res_o
);
  import mbs_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  cfg_t                cfg;
  logic                rd_en;
  logic [CW-1:0]       rd_addr;
  logic [LINE_W-1:0]   rd_data;
  logic                wr_en;
  logic [CW-1:0]       wr_addr;
  logic [LINE_W-1:0]   wr_data;
  logic                s1_valid;
  stage_t              s1_ctl;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [CW-1:0]       s1_addr;
  logic                out_full;

  mbs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbs_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .smp_i       (smp_i),
    .out_full_i  (out_full),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .s1_valid_o  (s1_valid),
    .s1_ctl_o    (s1_ctl),
    .s1_sample_o (s1_sample),
    .s1_addr_o   (s1_addr)
  );

  mbs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mbs_win #(
    .CW (CW)
  ) u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_ctl_i    (s1_ctl),
    .s1_sample_i (s1_sample),
    .s1_addr_i   (s1_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_full_o  (out_full),
    .res_o       (res_o)
  );

endmodule
